### rtl/core/usbdev_pkg.sv
// Types, codes and helpers shared by the USB device state and request handler.
package usbdev_pkg;

   // Device state as reported on the result channel
   typedef enum logic [2:0] {
      ST_DETACHED   = 3'd0,
      ST_ATTACHED   = 3'd1,
      ST_POWERED    = 3'd2,
      ST_DEFAULT    = 3'd3,
      ST_ADDRESS    = 3'd4,
      ST_CONFIGURED = 3'd5,
      ST_SUSPENDED  = 3'd6
   } dev_state_type;

   // Reply classification
   typedef enum logic [2:0] {
      RK_NONE    = 3'd0,
      RK_STATUS  = 3'd1,
      RK_DATA    = 3'd2,
      RK_STALL   = 3'd3,
      RK_FORWARD = 3'd4,
      RK_DESC    = 3'd5
   } reply_kind_type;

   // Request kind
   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_SETUP = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Bus event codes
   localparam logic [3:0] EV_RESET      = 4'd0;
   localparam logic [3:0] EV_SUSPEND    = 4'd1;
   localparam logic [3:0] EV_RESUME     = 4'd2;
   localparam logic [3:0] EV_CONNECT    = 4'd3;
   localparam logic [3:0] EV_DISCONNECT = 4'd4;
   localparam logic [3:0] EV_SETUP      = 4'd5;
   localparam logic [3:0] EV_XFER_DONE  = 4'd6;
   localparam logic [3:0] EV_SOF        = 4'd7;
   localparam logic [3:0] EV_ERROR      = 4'd8;
   localparam logic [3:0] EV_ENABLE     = 4'd9;
   localparam logic [3:0] EV_DISABLE    = 4'd10;

   // bmRequestType type field (bits 6:5)
   localparam logic [1:0] TYPE_STANDARD = 2'd0;
   localparam logic [1:0] TYPE_CLASS    = 2'd1;
   localparam logic [1:0] TYPE_VENDOR   = 2'd2;

   // bmRequestType recipient field (bits 4:0)
   localparam logic [4:0] RCP_DEVICE    = 5'd0;
   localparam logic [4:0] RCP_INTERFACE = 5'd1;
   localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

   // Standard request codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESC      = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;

   localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'h0000;

   // Endpoints brought up by configuration 1
   localparam logic [7:0] EP1_IN_ADDR  = 8'h81;
   localparam logic [7:0] EP1_OUT_ADDR = 8'h01;

   // Event counters
   localparam int         NUM_COUNTERS = 6;
   localparam logic [2:0] CNT_RESET    = 3'd0;
   localparam logic [2:0] CNT_SUSPEND  = 3'd1;
   localparam logic [2:0] CNT_RESUME   = 3'd2;
   localparam logic [2:0] CNT_SETUP    = 3'd3;
   localparam logic [2:0] CNT_XFER     = 3'd4;
   localparam logic [2:0] CNT_ERROR    = 3'd5;

   // Configuration register indexes
   localparam logic CSR_SUPPLY_OWN = 1'b0;
   localparam logic CSR_WAKE_HOST  = 1'b1;

   // Slot number of an endpoint address: number plus 16 for IN endpoints
   function automatic logic [4:0] ep_slot(input logic [7:0] addr);
      ep_slot = {addr[7], addr[3:0]};
   endfunction

endpackage

### rtl/core/usb_device_state_and_request_handler_unit.sv
// Top level of the USB device state and standard request handler.
//
// Requests arrive on the req_ channel (valid/stall); each is a bus event, a
// setup packet or a clear of the event counters. Every request yields exactly
// one response on the rsp_ channel carrying the device state, address and
// configuration after the request, the reply to a setup packet and the new
// value of the event counter the request touched.
// The state update and the response are computed from the request ports and
// land in the state and response registers at the accepting edge. Throughput
// is one request per cycle, set by the single response register; req_stall
// rises only while a response is held by rsp_stall, and the response register
// is refilled in the cycle it is taken.
// The csr_ port writes the self-powered status bit (index 0) and the remote
// wakeup status bit (index 1); write only while the block is idle.
// Synchronous reset puts the device in the detached state, clears address,
// configuration, all endpoint enabled and halted flags, the event counters,
// both configuration bits and the response valid.
module usb_device_state_and_request_handler_unit #(
   parameter int ENDPOINT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_event_code,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_device_state,
   output logic [6:0]  rsp_device_address,
   output logic        rsp_device_config,
   output logic [2:0]  rsp_reply_kind,
   output logic [15:0] rsp_reply_data,
   output logic [1:0]  rsp_reply_bytes,
   output logic [31:0] rsp_event_count,
   // configuration port
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic        csr_data
);

   localparam int SLOT_W = $clog2(ENDPOINT_SLOTS);
   localparam logic [4:0] IN1_SLOT  = usbdev_pkg::ep_slot(usbdev_pkg::EP1_IN_ADDR);
   localparam logic [4:0] OUT1_SLOT = usbdev_pkg::ep_slot(usbdev_pkg::EP1_OUT_ADDR);
   localparam bit IN1_OK  = int'(IN1_SLOT) < ENDPOINT_SLOTS;
   localparam bit OUT1_OK = int'(OUT1_SLOT) < ENDPOINT_SLOTS;

   // configuration
   logic supply_own_ff, wake_host_ff;

   // device state
   usbdev_pkg::dev_state_type link_state_ff, link_state_in;
   logic [6:0]                addr_ff, addr_in;
   logic                      config_ff, config_in;
   logic [ENDPOINT_SLOTS-1:0] ep_en_ff, ep_en_in;
   logic [ENDPOINT_SLOTS-1:0] ep_halt_ff, ep_halt_in;
   logic [31:0]               cnt_ff [usbdev_pkg::NUM_COUNTERS];
   logic [31:0]               cnt_in [usbdev_pkg::NUM_COUNTERS];

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   usbdev_pkg::reply_kind_type     reply_kind_ff, reply_kind_in;
   logic [15:0]                    reply_data_ff, reply_data_in;
   logic [1:0]                     reply_bytes_ff, reply_bytes_in;
   logic [31:0]                    event_count_ff, event_count_in;

   logic        accept;
   logic [4:0]  req_slot;
   logic        req_slot_ok;
   logic [SLOT_W-1:0] req_slot_idx;
   logic        ep_status;
   logic        cnt_bump;
   logic [2:0]  cnt_sel;
   logic [31:0] cnt_next;
   logic [1:0]  rtype_type;
   logic [4:0]  rtype_recip;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // endpoint named by the low byte of wIndex
   assign req_slot     = usbdev_pkg::ep_slot(req_request_index[7:0]);
   assign req_slot_ok  = (req_request_index[6:4] == 3'd0)
                         && (int'(req_slot) < ENDPOINT_SLOTS);
   assign req_slot_idx = req_slot[SLOT_W-1:0];
   assign ep_status    = req_slot_ok ? (ep_en_ff[req_slot_idx] & ep_halt_ff[req_slot_idx])
                                     : 1'b0;

   assign rtype_type  = req_request_type[6:5];
   assign rtype_recip = req_request_type[4:0];
   assign cnt_next    = cnt_ff[cnt_sel] + 32'd1;

   always_comb begin
      link_state_in  = link_state_ff;
      addr_in        = addr_ff;
      config_in      = config_ff;
      ep_en_in       = ep_en_ff;
      ep_halt_in     = ep_halt_ff;
      cnt_in         = cnt_ff;
      reply_kind_in  = usbdev_pkg::RK_NONE;
      reply_data_in  = 16'd0;
      reply_bytes_in = 2'd0;
      cnt_bump       = 1'b0;
      cnt_sel        = usbdev_pkg::CNT_RESET;

      unique case (req_kind)
         usbdev_pkg::KIND_EVENT: begin
            unique case (req_event_code)
               usbdev_pkg::EV_RESET: begin
                  link_state_in = usbdev_pkg::ST_DEFAULT;
                  addr_in       = 7'd0;
                  config_in     = 1'b0;
                  for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                     if ((i % 16) != 0) ep_en_in[i] = 1'b0;
                  end
                  cnt_bump = 1'b1;
                  cnt_sel  = usbdev_pkg::CNT_RESET;
               end
               usbdev_pkg::EV_SUSPEND: begin
                  if (link_state_ff != usbdev_pkg::ST_SUSPENDED) begin
                     link_state_in = usbdev_pkg::ST_SUSPENDED;
                     cnt_bump      = 1'b1;
                     cnt_sel       = usbdev_pkg::CNT_SUSPEND;
                  end
               end
               usbdev_pkg::EV_RESUME: begin
                  if (link_state_ff == usbdev_pkg::ST_SUSPENDED) begin
                     if (config_ff)
                        link_state_in = usbdev_pkg::ST_CONFIGURED;
                     else if (addr_ff != 7'd0)
                        link_state_in = usbdev_pkg::ST_ADDRESS;
                     else
                        link_state_in = usbdev_pkg::ST_DEFAULT;
                     cnt_bump = 1'b1;
                     cnt_sel  = usbdev_pkg::CNT_RESUME;
                  end
               end
               usbdev_pkg::EV_CONNECT: link_state_in = usbdev_pkg::ST_ATTACHED;
               usbdev_pkg::EV_DISCONNECT: begin
                  link_state_in = usbdev_pkg::ST_DETACHED;
                  addr_in       = 7'd0;
                  config_in     = 1'b0;
                  for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                     if ((i % 16) != 0) ep_en_in[i] = 1'b0;
                  end
               end
               usbdev_pkg::EV_SETUP: begin
                  cnt_bump = 1'b1;
                  cnt_sel  = usbdev_pkg::CNT_SETUP;
               end
               usbdev_pkg::EV_XFER_DONE: begin
                  cnt_bump = 1'b1;
                  cnt_sel  = usbdev_pkg::CNT_XFER;
               end
               usbdev_pkg::EV_ERROR: begin
                  cnt_bump = 1'b1;
                  cnt_sel  = usbdev_pkg::CNT_ERROR;
               end
               usbdev_pkg::EV_ENABLE:  link_state_in = usbdev_pkg::ST_POWERED;
               usbdev_pkg::EV_DISABLE: link_state_in = usbdev_pkg::ST_DETACHED;
               // start of frame and unknown codes change nothing
               default: ;
            endcase
         end
         usbdev_pkg::KIND_SETUP: begin
            if (rtype_type == usbdev_pkg::TYPE_CLASS || rtype_type == usbdev_pkg::TYPE_VENDOR) begin
               reply_kind_in = usbdev_pkg::RK_FORWARD;
            end else if (rtype_type != usbdev_pkg::TYPE_STANDARD) begin
               reply_kind_in = usbdev_pkg::RK_STALL;
            end else begin
               unique case (req_request_code)
                  usbdev_pkg::REQ_GET_STATUS: begin
                     reply_kind_in  = usbdev_pkg::RK_DATA;
                     reply_bytes_in = 2'd2;
                     if (rtype_recip == usbdev_pkg::RCP_DEVICE)
                        reply_data_in = {14'd0, wake_host_ff, supply_own_ff};
                     else if (rtype_recip == usbdev_pkg::RCP_INTERFACE)
                        reply_data_in = 16'd0;
                     else if (rtype_recip == usbdev_pkg::RCP_ENDPOINT)
                        reply_data_in = {15'd0, ep_status};
                     else begin
                        reply_kind_in  = usbdev_pkg::RK_STALL;
                        reply_bytes_in = 2'd0;
                     end
                  end
                  usbdev_pkg::REQ_CLEAR_FEATURE, usbdev_pkg::REQ_SET_FEATURE: begin
                     reply_kind_in = usbdev_pkg::RK_STATUS;
                     if (rtype_recip == usbdev_pkg::RCP_ENDPOINT
                         && req_request_value == usbdev_pkg::FEAT_ENDPOINT_HALT) begin
                        if (!req_slot_ok)
                           reply_kind_in = usbdev_pkg::RK_STALL;
                        else
                           ep_halt_in[req_slot_idx] =
                              (req_request_code == usbdev_pkg::REQ_SET_FEATURE);
                     end
                  end
                  usbdev_pkg::REQ_SET_ADDRESS: begin
                     reply_kind_in = usbdev_pkg::RK_STATUS;
                     addr_in       = req_request_value[6:0];
                     link_state_in = (req_request_value[6:0] != 7'd0)
                                     ? usbdev_pkg::ST_ADDRESS : usbdev_pkg::ST_DEFAULT;
                  end
                  usbdev_pkg::REQ_GET_DESC: reply_kind_in = usbdev_pkg::RK_DESC;
                  usbdev_pkg::REQ_GET_CONFIG: begin
                     reply_kind_in  = usbdev_pkg::RK_DATA;
                     reply_data_in  = {15'd0, config_ff};
                     reply_bytes_in = 2'd1;
                  end
                  usbdev_pkg::REQ_SET_CONFIG: begin
                     reply_kind_in = usbdev_pkg::RK_STATUS;
                     if (req_request_value[7:0] == 8'd0) begin
                        config_in     = 1'b0;
                        link_state_in = (addr_ff != 7'd0)
                                        ? usbdev_pkg::ST_ADDRESS : usbdev_pkg::ST_DEFAULT;
                        for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                           if ((i % 16) != 0) ep_en_in[i] = 1'b0;
                        end
                     end else if (req_request_value[7:0] == 8'd1) begin
                        config_in     = 1'b1;
                        link_state_in = usbdev_pkg::ST_CONFIGURED;
                        for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                           if ((IN1_OK && i == int'(IN1_SLOT))
                               || (OUT1_OK && i == int'(OUT1_SLOT))) begin
                              ep_en_in[i]   = 1'b1;
                              ep_halt_in[i] = 1'b0;
                           end
                        end
                     end else begin
                        reply_kind_in = usbdev_pkg::RK_STALL;
                     end
                  end
                  default: reply_kind_in = usbdev_pkg::RK_STALL;
               endcase
            end
         end
         usbdev_pkg::KIND_CLEAR: begin
            for (int i = 0; i < usbdev_pkg::NUM_COUNTERS; i++) cnt_in[i] = 32'd0;
         end
         default: ;
      endcase

      if (cnt_bump) cnt_in[cnt_sel] = cnt_next;
      event_count_in = cnt_bump ? cnt_next : 32'd0;
   end

   // hold a stalled response, drop it once taken
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_own_ff    <= 1'b0;
         wake_host_ff     <= 1'b0;
         link_state_ff    <= usbdev_pkg::ST_DETACHED;
         addr_ff          <= 7'd0;
         config_ff        <= 1'b0;
         ep_en_ff         <= '0;
         ep_halt_ff       <= '0;
         for (int i = 0; i < usbdev_pkg::NUM_COUNTERS; i++) cnt_ff[i] <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == usbdev_pkg::CSR_SUPPLY_OWN) supply_own_ff <= csr_data;
            if (csr_index == usbdev_pkg::CSR_WAKE_HOST) wake_host_ff <= csr_data;
         end
         if (accept) begin
            link_state_ff <= link_state_in;
            addr_ff       <= addr_in;
            config_ff     <= config_in;
            ep_en_ff      <= ep_en_in;
            ep_halt_ff    <= ep_halt_in;
            cnt_ff        <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         reply_kind_ff  <= reply_kind_in;
         reply_data_ff  <= reply_data_in;
         reply_bytes_ff <= reply_bytes_in;
         event_count_ff <= event_count_in;
      end
   end

   // state outputs follow the registered state, which changes only on accept
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_device_state   = link_state_ff;
   assign rsp_device_address = addr_ff;
   assign rsp_device_config  = config_ff;
   assign rsp_reply_kind     = reply_kind_ff;
   assign rsp_reply_data     = reply_data_ff;
   assign rsp_reply_bytes    = reply_bytes_ff;
   assign rsp_event_count    = event_count_ff;

endmodule

### rtl/core/usbdev_checker.sv
// Port-level assertions for the USB device state and request handler.
module usbdev_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_device_state,
   input logic [2:0]  rsp_reply_kind,
   input logic [15:0] rsp_reply_data,
   input logic [1:0]  rsp_reply_bytes,
   input logic [31:0] rsp_event_count
);

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_kind)
         && $stable(rsp_reply_data) && $stable(rsp_event_count)
         && $stable(rsp_device_state))
      else $error("stalled response changed");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // data bytes only accompany a data reply
   a_bytes_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_bytes != 2'd0
         |-> rsp_reply_kind == usbdev_pkg::RK_DATA && rsp_reply_bytes != 2'd3)
      else $error("reply bytes without data reply");

   // non-data replies carry a zero word
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind != usbdev_pkg::RK_DATA |-> rsp_reply_data == 16'd0)
      else $error("reply data on non-data reply");

   // the request side stalls only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

endmodule

bind usb_device_state_and_request_handler_unit usbdev_checker u_usbdev_checker (.*);
